// ===== sv/bsc_pkg.sv =====
// Package with payload types, calibration constants and register indexes for the compensation unit.
`timescale 1ns / 1ps

package bsc_pkg;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [16:0] temperature_centi;
      logic signed [31:0] fine_temperature;
      logic [31:0]        pressure_pa;
      logic               pressure_valid;
   } rsp_type;

   typedef struct packed {
      logic [47:0] temp_cal;
      logic [63:0] pres_lo;
      logic [63:0] pres_hi;
      logic [15:0] pres_last;
   } cal_type;

   localparam logic [1:0] REG_TEMP_CAL  = 2'd0;
   localparam logic [1:0] REG_PRES_LO   = 2'd1;
   localparam logic [1:0] REG_PRES_HI   = 2'd2;
   localparam logic [1:0] REG_PRES_LAST = 2'd3;

   localparam logic [31:0] PRES_OFFSET = 32'd64000;
   localparam logic [31:0] PRES_SCALE  = 32'd3125;
   localparam logic [31:0] PRES_BASE   = 32'd1048576;
   localparam int          DIV_STEPS   = 32;

   // Arithmetic shift right of a 32-bit word.
   function automatic logic [31:0] asr(input logic [31:0] v, input int s);
      return 32'($signed(v) >>> s);
   endfunction

   // Sign extension of a 16-bit calibration word.
   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

// ===== sv/bsc_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, 32 stages, with side payload.
`timescale 1ns / 1ps

module bsc_divider
   import bsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_dividend,
   input  logic [31:0] in_divisor,
   input  logic [63:0] in_side,
   output logic        out_valid,
   output logic [31:0] out_quotient,
   output logic [63:0] out_side
);

   logic [DIV_STEPS:0]        vld_ff;
   logic [DIV_STEPS:0][32:0]  rem_ff;
   logic [DIV_STEPS:0][31:0]  quo_ff;
   logic [DIV_STEPS:0][31:0]  dvs_ff;
   logic [DIV_STEPS:0][63:0]  side_ff;

   assign vld_ff[0]  = in_valid;
   assign rem_ff[0]  = '0;
   assign quo_ff[0]  = in_dividend;
   assign dvs_ff[0]  = in_divisor;
   assign side_ff[0] = in_side;

   // Each stage shifts in one dividend bit and subtracts the divisor where it fits.
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      logic [32:0] shifted_in;
      logic [33:0] diff_in;
      assign shifted_in = {rem_ff[i][31:0], quo_ff[i][31]};
      assign diff_in    = {1'b0, shifted_in} - {2'b0, dvs_ff[i]};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         rem_ff[i+1]  <= diff_in[33] ? shifted_in : diff_in[32:0];
         quo_ff[i+1]  <= {quo_ff[i][30:0], ~diff_in[33]};
         dvs_ff[i+1]  <= dvs_ff[i];
         side_ff[i+1] <= side_ff[i];
      end
   end

   assign out_valid    = vld_ff[DIV_STEPS];
   assign out_quotient = quo_ff[DIV_STEPS];
   assign out_side     = side_ff[DIV_STEPS];

endmodule

// ===== sv/bsc_front.sv =====
// Front pipeline: temperature compensation and the pressure divisor and dividend.
`timescale 1ns / 1ps

module bsc_front
   import bsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cal_type     cal,
   input  logic        in_valid,
   input  req_type     in_req,
   output logic        out_valid,
   output logic [31:0] out_dividend,
   output logic [31:0] out_divisor,
   output logic        out_high,
   output logic [31:0] out_tf,
   output logic [16:0] out_tc
);

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
   assign t1 = {16'd0, cal.temp_cal[15:0]};
   assign t2 = sx16(cal.temp_cal[31:16]);
   assign t3 = sx16(cal.temp_cal[47:32]);
   assign p1 = {16'd0, cal.pres_lo[15:0]};
   assign p2 = sx16(cal.pres_lo[31:16]);
   assign p3 = sx16(cal.pres_lo[47:32]);
   assign p4 = sx16(cal.pres_lo[63:48]);
   assign p5 = sx16(cal.pres_hi[15:0]);
   assign p6 = sx16(cal.pres_hi[31:16]);

   // Stage 1: first temperature products.
   logic        v1_ff;
   logic [31:0] a_ff, dd_ff;
   logic [19:0] ap1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= in_valid;
      a_ff   <= 32'(({15'd0, in_req.raw_temperature[19:3]} - (t1 << 1)) * t2);
      dd_ff  <= {16'd0, in_req.raw_temperature[19:4]} - t1;
      ap1_ff <= in_req.raw_pressure;
   end

   // Stage 2: square of the temperature difference.
   logic        v2_ff;
   logic [31:0] a2_ff, sq2_ff;
   logic [19:0] ap2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      a2_ff  <= asr(a_ff, 11);
      sq2_ff <= 32'(dd_ff * dd_ff);
      ap2_ff <= ap1_ff;
   end

   // Stage 3: second temperature term.
   logic        v3_ff;
   logic [31:0] a3_ff, b3_ff;
   logic [19:0] ap3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      a3_ff  <= a2_ff;
      b3_ff  <= 32'(asr(sq2_ff, 12) * t3);
      ap3_ff <= ap2_ff;
   end

   // Stage 4: fine temperature.
   logic        v4_ff;
   logic [31:0] tf4_ff;
   logic [19:0] ap4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      tf4_ff <= a3_ff + asr(b3_ff, 14);
      ap4_ff <= ap3_ff;
   end

   // Stage 5: centi-degrees, pressure offset and its square.
   logic        v5_ff;
   logic [31:0] tf5_ff, pv1_ff, sq5_ff;
   logic [16:0] tc5_ff;
   logic [19:0] ap5_ff;
   logic signed [35:0] tc_wide_in;
   logic [31:0] pv1_in, q_in;
   assign tc_wide_in = ($signed({{4{tf4_ff[31]}}, tf4_ff}) * 36'sd5 + 36'sd128) >>> 8;
   assign pv1_in     = asr(tf4_ff, 1) - PRES_OFFSET;
   assign q_in       = asr(pv1_in, 2);
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else v5_ff <= v4_ff;
      tf5_ff <= tf4_ff;
      if (tc_wide_in > 36'sd65535) tc5_ff <= 17'h0FFFF;
      else if (tc_wide_in < -36'sd65536) tc5_ff <= 17'h10000;
      else tc5_ff <= tc_wide_in[16:0];
      pv1_ff <= pv1_in;
      sq5_ff <= 32'(q_in * q_in);
      ap5_ff <= ap4_ff;
   end

   // Stage 6: the four pressure products.
   logic        v6_ff;
   logic [31:0] tf6_ff, m6a_ff, m6b_ff, m6c_ff, m6d_ff;
   logic [16:0] tc6_ff;
   logic [19:0] ap6_ff;
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else v6_ff <= v5_ff;
      tf6_ff <= tf5_ff;
      tc6_ff <= tc5_ff;
      ap6_ff <= ap5_ff;
      m6a_ff <= 32'(asr(sq5_ff, 11) * p6);
      m6b_ff <= 32'(pv1_ff * p5);
      m6c_ff <= 32'(p3 * asr(sq5_ff, 13));
      m6d_ff <= 32'(p2 * pv1_ff);
   end

   // Stage 7: sums towards the divisor and the offset term.
   logic        v7_ff;
   logic [31:0] tf7_ff, v27_ff, v17_ff;
   logic [16:0] tc7_ff;
   logic [19:0] ap7_ff;
   logic [31:0] v2s_in;
   assign v2s_in = m6a_ff + (m6b_ff << 1);
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else v7_ff <= v6_ff;
      tf7_ff <= tf6_ff;
      tc7_ff <= tc6_ff;
      ap7_ff <= ap6_ff;
      v27_ff <= asr(v2s_in, 2) + (p4 << 16);
      v17_ff <= 32'(32'd32768 + asr(asr(m6c_ff, 3) + asr(m6d_ff, 1), 18));
   end

   // Stage 8: divisor product and dividend before scaling.
   logic        v8_ff;
   logic [31:0] tf8_ff, dv8_ff, pr8_ff;
   logic [16:0] tc8_ff;
   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else v8_ff <= v7_ff;
      tf8_ff <= tf7_ff;
      tc8_ff <= tc7_ff;
      dv8_ff <= 32'(v17_ff * p1);
      pr8_ff <= PRES_BASE - {12'd0, ap7_ff} - asr(v27_ff, 12);
   end

   // Stage 9: final divisor and scaled dividend.
   logic        v9_ff, hi9_ff;
   logic [31:0] tf9_ff, dv9_ff, pd9_ff;
   logic [16:0] tc9_ff;
   logic [31:0] p_in;
   assign p_in = 32'(pr8_ff * PRES_SCALE);
   always_ff @(posedge clock) begin
      if (reset) v9_ff <= 1'b0;
      else v9_ff <= v8_ff;
      tf9_ff <= tf8_ff;
      tc9_ff <= tc8_ff;
      dv9_ff <= asr(dv8_ff, 15);
      hi9_ff <= p_in[31];
      pd9_ff <= p_in[31] ? p_in : (p_in << 1);
   end

   assign out_valid    = v9_ff;
   assign out_dividend = pd9_ff;
   assign out_divisor  = dv9_ff;
   assign out_high     = hi9_ff;
   assign out_tf       = tf9_ff;
   assign out_tc       = tc9_ff;

endmodule

// ===== sv/bsc_back.sv =====
// Back pipeline: second-order pressure correction after the division.
`timescale 1ns / 1ps

module bsc_back
   import bsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cal_type     cal,
   input  logic        in_valid,
   input  logic [31:0] in_quotient,
   input  logic        in_high,
   input  logic        in_zero,
   input  logic [31:0] in_tf,
   input  logic [16:0] in_tc,
   output logic        out_valid,
   output rsp_type     out_rsp
);

   logic [31:0] p7, p8, p9;
   assign p7 = sx16(cal.pres_hi[47:32]);
   assign p8 = sx16(cal.pres_hi[63:48]);
   assign p9 = sx16(cal.pres_last);

   // Stage 1: quotient scaling and square term.
   logic        v1_ff, z1_ff;
   logic [31:0] p1_ff, sq1_ff, tf1_ff;
   logic [16:0] tc1_ff;
   logic [31:0] p_in;
   assign p_in = in_high ? (in_quotient << 1) : in_quotient;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= in_valid;
      z1_ff  <= in_zero;
      p1_ff  <= p_in;
      sq1_ff <= 32'({3'd0, p_in[31:3]} * {3'd0, p_in[31:3]});
      tf1_ff <= in_tf;
      tc1_ff <= in_tc;
   end

   // Stage 2: correction products.
   logic        v2_ff, z2_ff;
   logic [31:0] p2_ff, a2_ff, b2_ff, tf2_ff;
   logic [16:0] tc2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      z2_ff  <= z1_ff;
      p2_ff  <= p1_ff;
      a2_ff  <= 32'(p9 * {13'd0, sq1_ff[31:13]});
      b2_ff  <= 32'({2'd0, p1_ff[31:2]} * p8);
      tf2_ff <= tf1_ff;
      tc2_ff <= tc1_ff;
   end

   // Stage 3: final sum and result register.
   rsp_type     rsp_ff;
   logic        v3_ff;
   logic [31:0] corr_in;
   assign corr_in = asr(asr(a2_ff, 12) + asr(b2_ff, 13) + p7, 4);
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      rsp_ff.temperature_centi <= tc2_ff;
      rsp_ff.fine_temperature  <= tf2_ff;
      rsp_ff.pressure_pa       <= z2_ff ? 32'd0 : (p2_ff + corr_in);
      rsp_ff.pressure_valid    <= ~z2_ff;
   end

   assign out_valid = v3_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ===== sv/baro_sensor_compensation_unit.sv =====
// Top level of the barometric sensor compensation unit.
//
//   Channel | Direction | Handshake             | Payload
//   req_    | in        | start high, busy low  | req_data (req_type)
//   rsp_    | out       | rsp_strobe, one cycle | rsp_data (rsp_type)
//   csr_    | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// One reading is taken every cycle; busy is always low.
// The pipeline has 9 front stages, 32 divider stages and 3 back stages.
// The 32-stage divider, one quotient bit per stage, is the largest part of the pipeline.
// Synchronous reset clears valid bits and calibration; the receiver cannot stall.
`timescale 1ns / 1ps

module baro_sensor_compensation_unit
   import bsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   cal_type cal_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Calibration register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_TEMP_CAL:  cal_ff.temp_cal  <= csr_data[47:0];
            REG_PRES_LO:   cal_ff.pres_lo   <= csr_data;
            REG_PRES_HI:   cal_ff.pres_hi   <= csr_data;
            REG_PRES_LAST: cal_ff.pres_last <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic        f_valid, f_high;
   logic [31:0] f_dividend, f_divisor, f_tf;
   logic [16:0] f_tc;

   bsc_front u_front (
      .clock(clock), .reset(reset), .cal(cal_ff),
      .in_valid(start & ~busy), .in_req(req_data),
      .out_valid(f_valid), .out_dividend(f_dividend), .out_divisor(f_divisor),
      .out_high(f_high), .out_tf(f_tf), .out_tc(f_tc)
   );

   // Side payload carried alongside the division.
   logic [63:0] side_in, side_out;
   logic        d_valid;
   logic [31:0] d_quotient;
   assign side_in = {13'd0, f_high, (f_divisor == 32'd0), f_tc, f_tf};

   bsc_divider u_div (
      .clock(clock), .reset(reset), .in_valid(f_valid),
      .in_dividend(f_dividend), .in_divisor(f_divisor), .in_side(side_in),
      .out_valid(d_valid), .out_quotient(d_quotient), .out_side(side_out)
   );

   bsc_back u_back (
      .clock(clock), .reset(reset), .cal(cal_ff),
      .in_valid(d_valid), .in_quotient(d_quotient),
      .in_high(side_out[50]), .in_zero(side_out[49]),
      .in_tf(side_out[31:0]), .in_tc(side_out[48:32]),
      .out_valid(rsp_strobe), .out_rsp(rsp_data)
   );

endmodule

// ===== sv/bsc_checker.sv =====
// Port-level checker for the compensation unit and its bind statement.
`timescale 1ns / 1ps

module bsc_checker
   import bsc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // An invalid pressure always reads as zero.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.pressure_valid |-> rsp_data.pressure_pa == 32'd0)
      else $error("invalid pressure not zero");

   // Every accepted reading gives a result once it has passed through the whole pipeline.
   a_lat: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##44 rsp_strobe)
      else $error("result missing");

   // No result without a reading.
   a_nogen: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 44))
      else $error("spurious result");

   // The unit never stalls its input.
   a_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");

endmodule

bind baro_sensor_compensation_unit bsc_checker u_bsc_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
);
